[rtl/polar_decomposition_3x3_defines.svh]
// ----------------------------------------------------------------------------
// Polar decomposition assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef POLAR_DECOMPOSITION_3X3_DEFINES_SVH
`define POLAR_DECOMPOSITION_3X3_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PD_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("pd checker: port property failed");

// next-cycle implication
`define PD_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("pd checker: port property failed");

`endif

[rtl/pd_pkg.sv]
// ----------------------------------------------------------------------------
// Polar decomposition package
// Opcodes, sequencer types, scratch memory map and the microcode function.
// ----------------------------------------------------------------------------
package pd_pkg;

	typedef enum logic [3:0] {
		OP_LDIN, OP_MUL_LD, OP_MUL_ADD, OP_MUL_SUB, OP_ST, OP_ST_DET,
		OP_DIV, OP_AVG, OP_LD_ONE, OP_LD_ZERO, OP_OCOL, OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		SEG_LOAD, SEG_CG, SEG_INIT, SEG_INV, SEG_MMCU, SEG_AVG, SEG_MMGI, SEG_OUT
	} seg_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_FETCH, ST_EXEC, ST_MWAIT, ST_DWAIT
	} state_t;

	localparam int AW = 6;
	typedef logic [AW-1:0] addr_t;

	typedef struct packed {
		op_t   op;
		addr_t a;
		addr_t b;
		addr_t d;
	} instr_t;

	// scratch memory map
	localparam addr_t BASE_G   = 6'd0;
	localparam addr_t BASE_C   = 6'd9;
	localparam addr_t BASE_U   = 6'd18;
	localparam addr_t BASE_I   = 6'd27;
	localparam addr_t BASE_T   = 6'd36;
	localparam addr_t BASE_COF = 6'd45;
	localparam addr_t ADDR_K1  = 6'd54;

	// cofactor operand indices p,q,r,s: p*q - r*s; last row is the det helper
	localparam logic [3:0] COF_TAB [10][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8},
		'{4'd1, 4'd5, 4'd2, 4'd4}, '{4'd5, 4'd6, 4'd3, 4'd8},
		'{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd3, 4'd2, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd0, 4'd7},
		'{4'd0, 4'd4, 4'd1, 4'd3}, '{4'd3, 4'd8, 4'd5, 4'd6}
	};

	function automatic addr_t seg_len(seg_t s);
		addr_t n;
		case (s)
			SEG_LOAD: n = 6'd9;
			SEG_CG:   n = 6'd36;
			SEG_INIT: n = 6'd9;
			SEG_INV:  n = 6'd43;
			SEG_MMCU: n = 6'd36;
			SEG_AVG:  n = 6'd9;
			SEG_MMGI: n = 6'd36;
			SEG_OUT:  n = 6'd24;
			default:  n = 6'd1;
		endcase
		return n;
	endfunction

	function automatic addr_t div3(addr_t v);
		addr_t q;
		q = '0;
		for (int t = 1; t < 22; t++) begin
			if (v >= AW'(3 * t)) q = AW'(t);
		end
		return q;
	endfunction

	// one multiply-accumulate element: four steps, three products then store
	function automatic instr_t mm(addr_t pc, addr_t ab, logic at, addr_t bb, logic bt,
			addr_t db);
		instr_t r;
		addr_t e, k, i, j;
		e = {2'b00, pc[5:2]};
		k = {4'b0000, pc[1:0]};
		i = div3(e);
		j = e - 6'(3 * i);
		r.a = ab + (at ? 6'(k * 3 + i) : 6'(i * 3 + k));
		r.b = bb + (bt ? 6'(j * 3 + k) : 6'(k * 3 + j));
		r.d = db + e;
		if (k == 6'd3) r.op = OP_ST;
		else if (k == 6'd0) r.op = OP_MUL_LD;
		else r.op = OP_MUL_ADD;
		return r;
	endfunction

	// inverse of U: cofactors, determinant, then nine divides
	function automatic instr_t inv(addr_t pc);
		instr_t r;
		addr_t n, m;
		n = div3(pc);
		m = pc - 6'(3 * n);
		r = '{OP_LD_ZERO, '0, '0, '0};
		if (pc < 6'd30) begin
			if (m == 6'd0) begin
				r.op = OP_MUL_LD;
				r.a = BASE_U + 6'(COF_TAB[n[3:0]][0]);
				r.b = BASE_U + 6'(COF_TAB[n[3:0]][1]);
			end else if (m == 6'd1) begin
				r.op = OP_MUL_SUB;
				r.a = BASE_U + 6'(COF_TAB[n[3:0]][2]);
				r.b = BASE_U + 6'(COF_TAB[n[3:0]][3]);
			end else begin
				r.op = OP_ST;
				r.d = (n == 6'd9) ? ADDR_K1 : BASE_COF + n;
			end
		end else if (pc == 6'd30) begin
			r.op = OP_MUL_LD;  r.a = BASE_U;         r.b = BASE_COF;
		end else if (pc == 6'd31) begin
			r.op = OP_MUL_SUB; r.a = BASE_U + 6'd1;  r.b = ADDR_K1;
		end else if (pc == 6'd32) begin
			r.op = OP_MUL_ADD; r.a = BASE_U + 6'd2;  r.b = BASE_COF + 6'd6;
		end else if (pc == 6'd33) begin
			r.op = OP_ST_DET;
		end else begin
			r.op = OP_DIV;
			r.a = BASE_COF + (pc - 6'd34);
			r.d = BASE_I + (pc - 6'd34);
		end
		return r;
	endfunction

	function automatic instr_t pd_ucode(seg_t s, addr_t pc);
		instr_t r;
		addr_t row, rr, c;
		row = {3'b000, pc[4:2]};
		c = {4'b0000, pc[1:0]};
		rr = (row >= 6'd3) ? row - 6'd3 : row;
		r = '{OP_LD_ZERO, '0, '0, '0};
		case (s)
			SEG_LOAD: begin
				r.op = OP_LDIN; r.a = pc; r.d = BASE_G + pc;
			end
			SEG_CG:   r = mm(pc, BASE_G, 1'b1, BASE_G, 1'b0, BASE_C);
			SEG_INIT: begin
				r.op = (pc == 6'd0 || pc == 6'd4 || pc == 6'd8) ? OP_LD_ONE : OP_LD_ZERO;
				r.d = BASE_U + pc;
			end
			SEG_INV:  r = inv(pc);
			SEG_MMCU: r = mm(pc, BASE_C, 1'b0, BASE_I, 1'b1, BASE_T);
			SEG_AVG: begin
				r.op = OP_AVG; r.a = BASE_U + pc; r.b = BASE_T + pc; r.d = BASE_U + pc;
			end
			SEG_MMGI: r = mm(pc, BASE_G, 1'b0, BASE_I, 1'b0, BASE_T);
			SEG_OUT: begin
				r.op = (c == 6'd3) ? OP_EMIT : OP_OCOL;
				r.a = ((row >= 6'd3) ? BASE_T : BASE_U) + 6'(rr * 3) + c;
				r.d = c;
			end
			default: r = '{OP_LD_ZERO, '0, '0, '0};
		endcase
		return r;
	endfunction

endpackage

[rtl/pd_if.sv]
// ----------------------------------------------------------------------------
// Polar decomposition channel interfaces
// Gradient input, matrix row output and iteration count write channel.
// ----------------------------------------------------------------------------
interface pd_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] f11, f12, f13, f21, f22, f23, f31, f32, f33;
	modport source(output valid, f11, f12, f13, f21, f22, f23, f31, f32, f33,
		input ready);
	modport sink(input valid, f11, f12, f13, f21, f22, f23, f31, f32, f33,
		output ready);
endinterface

interface pd_out_if;
	logic valid;
	logic ready;
	logic which_matrix;
	logic [1:0] row_index;
	logic signed [31:0] col0_value, col1_value, col2_value;
	logic singular;
	logic last_row;
	modport source(output valid, which_matrix, row_index, col0_value, col1_value,
		col2_value, singular, last_row, input ready);
	modport sink(input valid, which_matrix, row_index, col0_value, col1_value,
		col2_value, singular, last_row, output ready);
endinterface

interface pd_cfg_if;
	logic valid;
	logic ready;
	logic [4:0] iteration_count;
	modport source(output valid, iteration_count, input ready);
	modport sink(input valid, iteration_count, output ready);
endinterface

[rtl/polar_decomposition_3x3.sv]
// ----------------------------------------------------------------------------
// Polar decomposition of a 3x3 deformation gradient
// Newton square root of C = F'F under a microcoded sequencer that drives one
// shared multiplier, one serial divider and a two-read scratch memory.
// ----------------------------------------------------------------------------
// Usage:
//   gradient: one request carries F (f11..f33, signed Q15.16). It is taken
//     only while the block is idle; ready stays low until the item is done.
//   result: six requests per item, rows 0..2 of U (which_matrix 0), then
//     rows 0..2 of R (which_matrix 1); last_row marks the final R row and
//     singular is the same on all six.
//   iter_cfg: writes iteration_count (reset 15); always ready, write only
//     while idle.
// Sequencing: the shared multiplier sums four partial products per product,
//   the divider is serial, and every microinstruction passes a fetch state
//   that reads the scratch memory. One item at a time: a new gradient is not
//   taken until the sequencer is back in idle.
// Reset: the sequencer goes idle, pending output is dropped, the count
//   returns to 15. A stalled result holds in its output register; the
//   sequencer waits at the next row until the register frees.
// ----------------------------------------------------------------------------
module polar_decomposition_3x3 #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input logic  clk,
	input logic  arst_n,
	pd_cfg_if.sink   iter_cfg,
	pd_in_if.sink    gradient,
	pd_out_if.source result
);
	import pd_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int XW = ((W > 32) ? W : 32) + 1;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ONE =
		(FRAC_BITS >= W - 1) ? WMAX : (W'(1) << FRAC_BITS);

	state_t state_q, state_d;
	seg_t   seg_q, seg_d;
	addr_t  pc_q, pc_d;
	logic [4:0] pass_q, pass_d, iter_q;
	logic   final_q, final_d, sing_q;
	logic signed [W-1:0] acc_q, acc_d, det_q;
	logic signed [31:0]  in_q [9];
	logic [W-1:0] mem_q [64];
	logic signed [W-1:0] rda_q, rdb_q;
	instr_t ins;

	logic   we, acc_ld, det_ld, col_ld, emit, mul_go, div_go, adv;
	logic signed [W-1:0] wd, mres, dres;
	logic   mdone, ddone;

	logic   out_valid_q, which_q, last_q, osing_q;
	logic [1:0] row_q;
	logic signed [31:0] col_q [3];
	logic [2:0] orow;

	function automatic logic signed [W-1:0] sat_in(logic signed [31:0] v);
		logic signed [XW-1:0] x;
		x = XW'(v);
		if (x > XW'(WMAX)) return WMAX;
		if (x < XW'(WMIN)) return WMIN;
		return W'(x);
	endfunction

	function automatic logic signed [31:0] out32(logic signed [W-1:0] v);
		logic signed [XW-1:0] x;
		x = XW'(v);
		if (x > XW'(33'sh0_7FFF_FFFF)) return 32'sh7FFF_FFFF;
		if (x < XW'(-33'sh0_8000_0000)) return 32'sh8000_0000;
		return 32'(x);
	endfunction

	function automatic logic signed [W-1:0] addsub(logic signed [W-1:0] a,
			logic signed [W-1:0] b, logic sub);
		logic signed [W:0] s;
		s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
		if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
		return s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] average(logic signed [W-1:0] a,
			logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		return s[W:1];
	endfunction

	assign ins = pd_ucode(seg_q, pc_q);

	pd_mul #(.W(W), .F(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go), .a(rda_q), .b(rdb_q),
		.done(mdone), .res(mres)
	);

	pd_div #(.W(W), .F(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .n(rda_q), .d(det_q),
		.done(ddone), .res(dres)
	);

	assign iter_cfg.ready = 1'b1;
	assign gradient.ready = (state_q == ST_IDLE);
	assign result.valid        = out_valid_q;
	assign result.which_matrix = which_q;
	assign result.row_index    = row_q;
	assign result.col0_value   = col_q[0];
	assign result.col1_value   = col_q[1];
	assign result.col2_value   = col_q[2];
	assign result.singular     = osing_q;
	assign result.last_row     = last_q;
	assign orow = pc_q[4:2];

	always_comb begin
		state_d = state_q;
		seg_d   = seg_q;
		pc_d    = pc_q;
		pass_d  = pass_q;
		final_d = final_q;
		acc_d   = acc_q;
		we = 1'b0; wd = '0; acc_ld = 1'b0; det_ld = 1'b0; col_ld = 1'b0;
		emit = 1'b0; mul_go = 1'b0; div_go = 1'b0; adv = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (gradient.valid) begin
					state_d = ST_FETCH;
					seg_d   = SEG_LOAD;
					pc_d    = '0;
					pass_d  = '0;
					final_d = 1'b0;
				end
			end
			ST_FETCH: state_d = ST_EXEC;
			ST_EXEC: begin
				case (ins.op)
					OP_LDIN:    begin we = 1'b1; wd = sat_in(in_q[ins.a[3:0]]); adv = 1'b1; end
					OP_MUL_LD, OP_MUL_ADD, OP_MUL_SUB: begin
						mul_go = 1'b1; state_d = ST_MWAIT;
					end
					OP_ST:      begin we = 1'b1; wd = acc_q; adv = 1'b1; end
					OP_ST_DET:  begin det_ld = 1'b1; adv = 1'b1; end
					OP_AVG:     begin we = 1'b1; wd = average(rda_q, rdb_q); adv = 1'b1; end
					OP_LD_ONE:  begin we = 1'b1; wd = ONE; adv = 1'b1; end
					OP_LD_ZERO: begin we = 1'b1; wd = '0; adv = 1'b1; end
					OP_OCOL: begin
						// row register is busy until the pending request leaves
						if (!out_valid_q || result.ready) begin
							col_ld = 1'b1; adv = 1'b1;
						end
					end
					OP_DIV: begin
						if (det_q == '0) begin
							// singular: sign of the cofactor saturates
							we  = 1'b1;
							wd  = (rda_q > 0) ? WMAX : ((rda_q < 0) ? WMIN : '0);
							adv = 1'b1;
						end else begin
							div_go = 1'b1; state_d = ST_DWAIT;
						end
					end
					OP_EMIT: begin
						if (!out_valid_q || result.ready) begin
							emit = 1'b1; adv = 1'b1;
						end
					end
					default: adv = 1'b1;
				endcase
			end
			ST_MWAIT: begin
				if (mdone) begin
					acc_ld = 1'b1;
					acc_d  = (ins.op == OP_MUL_LD) ? mres
						: addsub(acc_q, mres, ins.op == OP_MUL_SUB);
					adv = 1'b1;
				end
			end
			ST_DWAIT: begin
				if (ddone) begin
					we = 1'b1; wd = dres; adv = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		if (adv) begin
			state_d = ST_FETCH;
			if (pc_q == seg_len(seg_q) - 6'd1) begin
				pc_d = '0;
				case (seg_q)
					SEG_LOAD: seg_d = SEG_CG;
					SEG_CG:   seg_d = SEG_INIT;
					SEG_INIT: begin
						seg_d = SEG_INV; final_d = (iter_q == 5'd0);
					end
					SEG_INV:  seg_d = final_q ? SEG_MMGI : SEG_MMCU;
					SEG_MMCU: seg_d = SEG_AVG;
					SEG_AVG: begin
						seg_d = SEG_INV;
						if (5'(pass_q + 5'd1) == iter_q) final_d = 1'b1;
						else pass_d = pass_q + 5'd1;
					end
					SEG_MMGI: seg_d = SEG_OUT;
					SEG_OUT:  state_d = ST_IDLE;
					default:  state_d = ST_IDLE;
				endcase
			end else begin
				pc_d = pc_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seg_q       <= SEG_LOAD;
			pc_q        <= '0;
			pass_q      <= '0;
			final_q     <= 1'b0;
			sing_q      <= 1'b0;
			iter_q      <= 5'd15;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			seg_q   <= seg_d;
			pc_q    <= pc_d;
			pass_q  <= pass_d;
			final_q <= final_d;
			if (iter_cfg.valid) iter_q <= iter_cfg.iteration_count;
			if (gradient.valid && gradient.ready) sing_q <= 1'b0;
			else if (det_ld && acc_q == '0) sing_q <= 1'b1;
			if (emit) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (gradient.valid && gradient.ready) begin
			in_q[0] <= gradient.f11; in_q[1] <= gradient.f12; in_q[2] <= gradient.f13;
			in_q[3] <= gradient.f21; in_q[4] <= gradient.f22; in_q[5] <= gradient.f23;
			in_q[6] <= gradient.f31; in_q[7] <= gradient.f32; in_q[8] <= gradient.f33;
		end
		if (we) mem_q[ins.d] <= wd;
		rda_q <= mem_q[ins.a];
		rdb_q <= mem_q[ins.b];
		if (acc_ld) acc_q <= acc_d;
		if (det_ld) det_q <= acc_q;
		if (col_ld) col_q[ins.d[1:0]] <= out32(rda_q);
		if (emit) begin
			which_q <= (orow >= 3'd3);
			row_q   <= (orow >= 3'd3) ? 2'(orow - 3'd3) : orow[1:0];
			last_q  <= (orow == 3'd5);
			osing_q <= sing_q;
		end
	end
endmodule

[rtl/pd_mul.sv]
// ----------------------------------------------------------------------------
// Polar decomposition shared multiplier
// Fixed point product from four half-width partial products, floor rounding,
// saturated to the word range.
// ----------------------------------------------------------------------------
module pd_mul #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic                done,
	output logic signed [W-1:0] res
);
	localparam int H = (W + 1) / 2;
	localparam int L = 2 * H;
	localparam logic [2*L-1:0] LIM = ({{(2*L-1){1'b0}}, 1'b1} << (W - 1)) - 1'b1;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

	logic [L-1:0]   x_q, y_q;
	logic           neg_q;
	logic [2*L-1:0] prod_q;
	logic [2:0]     cnt_q;
	logic           busy_q;
	logic [H-1:0]   xs, ys;
	logic [L-1:0]   pp;
	logic [2*L-1:0] pps, qv, qr;
	logic           rest;
	logic signed [W-1:0] fin;

	function automatic logic [L-1:0] mag(logic signed [W-1:0] v);
		logic [W-1:0] m;
		m = v[W-1] ? (~v + 1'b1) : v;
		return L'(m);
	endfunction

	assign xs  = cnt_q[0] ? x_q[L-1:H] : x_q[H-1:0];
	assign ys  = cnt_q[1] ? y_q[L-1:H] : y_q[H-1:0];
	assign pp  = {{H{1'b0}}, xs} * {{H{1'b0}}, ys};
	assign pps = {{L{1'b0}}, pp} << ((cnt_q[0] ? H : 0) + (cnt_q[1] ? H : 0));

	always_comb begin
		rest = |prod_q[F-1:0];
		qv = prod_q >> F;
		qr = qv + {{(2*L-1){1'b0}}, (neg_q && rest)};
		if (qr > LIM) fin = neg_q ? WMIN : WMAX;
		else fin = neg_q ? -W'(qr) : W'(qr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= mag(a);
			y_q    <= mag(b);
			neg_q  <= a[W-1] ^ b[W-1];
			prod_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4) res <= fin;
			else prod_q <= prod_q + pps;
		end
	end
endmodule

[rtl/pd_div.sv]
// ----------------------------------------------------------------------------
// Polar decomposition serial divider
// Restoring divide, one quotient bit a cycle: cofactor * 2^F / determinant,
// truncated toward zero and saturated to the word range.
// ----------------------------------------------------------------------------
module pd_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] n,
	input  logic signed [W-1:0] d,
	output logic                done,
	output logic signed [W-1:0] res
);
	localparam int N  = W + F;
	localparam int CW = $clog2(N + 1);
	localparam logic [N-1:0] LIM = ({{(N-1){1'b0}}, 1'b1} << (W - 1)) - 1'b1;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

	logic [N-1:0]  num_q, quo_q;
	logic [W-1:0]  md_q, rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, neg_q;
	logic [W:0]    rsh;
	logic          ge;
	logic signed [W-1:0] fin;

	function automatic logic [W-1:0] mag(logic signed [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	assign rsh = {rem_q, num_q[N-1]};
	assign ge  = rsh >= {1'b0, md_q};

	always_comb begin
		if (quo_q > LIM) fin = neg_q ? WMIN : WMAX;
		else fin = neg_q ? -W'(quo_q) : W'(quo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {mag(n), {F{1'b0}}};
			md_q  <= mag(d);
			neg_q <= n[W-1] ^ d[W-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				res <= fin;
			end else begin
				// remainder stays below the divisor, so W bits hold it
				rem_q <= ge ? W'(rsh - {1'b0, md_q}) : W'(rsh);
				quo_q <= {quo_q[N-2:0], ge};
				num_q <= num_q << 1;
			end
		end
	end
endmodule

[rtl/pd_checker.sv]
// ----------------------------------------------------------------------------
// Polar decomposition port checker
// Watches the top level's channels: row fields, input busy, output hold.
// ----------------------------------------------------------------------------
`include "polar_decomposition_3x3_defines.svh"

module pd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_which_matrix,
	input logic [1:0]  out_row_index,
	input logic [31:0] out_col0_value,
	input logic        out_last_row
);
	`PD_ASSERT_IMP(a_row_range, out_valid, out_row_index != 2'd3)
	`PD_ASSERT_IMP(a_last_on_r, out_valid && out_last_row, out_which_matrix && out_row_index == 2'd2)
	`PD_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready)
	`PD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_col0_value))
endmodule

bind polar_decomposition_3x3 pd_checker u_pd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(gradient.valid),
	.in_ready(gradient.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_which_matrix(result.which_matrix),
	.out_row_index(result.row_index),
	.out_col0_value(result.col0_value),
	.out_last_row(result.last_row)
);

[verif/polar_decomposition_3x3_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polar decomposition testbench
// Sends 3x3 gradients through the block under several iteration counts and
// traffic patterns, predicts the six U and R rows of each request in fixed
// point and compares every returned row field by field.
// ----------------------------------------------------------------------------
module polar_decomposition_3x3_tb;

	localparam longint ONE  = 64'sd65536;
	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;

	typedef longint mat_t [9];

	typedef struct {
		logic        which_matrix;
		logic [1:0]  row_index;
		logic [31:0] col0_value;
		logic [31:0] col1_value;
		logic [31:0] col2_value;
		logic        singular;
		logic        last_row;
	} row_t;

	class polar_scoreboard;
		row_t     pending_rows[$];
		int       mismatches;
		int       rows_checked;
		int       gradients_seen;
		int       singular_seen;
		bit [4:0] passes;

		function new();
			mismatches = 0;
			rows_checked = 0;
			gradients_seen = 0;
			singular_seen = 0;
			passes = 5'd15;
		endfunction

		function longint clip(longint v);
			if (v > WMAX) return WMAX;
			if (v < WMIN) return WMIN;
			return v;
		endfunction

		// arithmetic shift gives the floor of the scaled product
		function longint qmul(longint a, longint b);
			return clip((a * b) >>> 16);
		endfunction

		function longint cofactor(longint p, longint q, longint r, longint s);
			return clip(qmul(p, q) - qmul(r, s));
		endfunction

		function void matmul(input mat_t a, input mat_t b, output mat_t r);
			longint acc;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					acc = 0;
					for (int k = 0; k < 3; k++)
						acc = clip(acc + qmul(a[i*3+k], b[k*3+j]));
					r[i*3+j] = acc;
				end
		endfunction

		function void invert(input mat_t a, output mat_t r, inout bit sing);
			longint c[9];
			longint det;
			c[0] = cofactor(a[4], a[8], a[5], a[7]);
			c[1] = cofactor(a[2], a[7], a[1], a[8]);
			c[2] = cofactor(a[1], a[5], a[2], a[4]);
			c[3] = cofactor(a[5], a[6], a[3], a[8]);
			c[4] = cofactor(a[0], a[8], a[2], a[6]);
			c[5] = cofactor(a[3], a[2], a[0], a[5]);
			c[6] = cofactor(a[3], a[7], a[6], a[4]);
			c[7] = cofactor(a[6], a[1], a[0], a[7]);
			c[8] = cofactor(a[0], a[4], a[1], a[3]);
			det = clip(qmul(a[0], c[0]) - qmul(a[1], cofactor(a[3], a[8], a[5], a[6])));
			det = clip(det + qmul(a[2], cofactor(a[3], a[7], a[4], a[6])));
			if (det == 0) sing = 1'b1;
			for (int i = 0; i < 9; i++) begin
				if (det != 0) r[i] = clip((c[i] * ONE) / det);
				else r[i] = (c[i] > 0) ? WMAX : ((c[i] < 0) ? WMIN : 0);
			end
		endfunction

		function void note_gradient(input mat_t f);
			mat_t ft, cg, u, ui, uit, t, rot;
			bit   sing;
			row_t row;
			sing = 1'b0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					ft[i*3+j] = f[j*3+i];
			matmul(ft, f, cg);
			for (int i = 0; i < 9; i++) u[i] = (i % 4 == 0) ? ONE : 0;
			for (int p = 0; p < passes; p++) begin
				invert(u, ui, sing);
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						uit[i*3+j] = ui[j*3+i];
				matmul(cg, uit, t);
				for (int i = 0; i < 9; i++) u[i] = (u[i] + t[i]) >>> 1;
			end
			invert(u, ui, sing);
			matmul(f, ui, rot);
			for (int n = 0; n < 6; n++) begin
				row.which_matrix = (n >= 3);
				row.row_index    = 2'(n % 3);
				row.col0_value   = 32'((n < 3) ? u[(n%3)*3]   : rot[(n%3)*3]);
				row.col1_value   = 32'((n < 3) ? u[(n%3)*3+1] : rot[(n%3)*3+1]);
				row.col2_value   = 32'((n < 3) ? u[(n%3)*3+2] : rot[(n%3)*3+2]);
				row.singular     = sing;
				row.last_row     = (n == 5);
				pending_rows.push_back(row);
			end
			gradients_seen++;
			if (sing) singular_seen++;
		endfunction

		function void check_row(row_t got);
			row_t want;
			if (pending_rows.size() == 0) begin
				$error("unexpected result row: no row pending");
				mismatches++;
				return;
			end
			want = pending_rows.pop_front();
			rows_checked++;
			if (got.which_matrix !== want.which_matrix) begin
				$error("which_matrix: expected %0d, got %0d", want.which_matrix,
					got.which_matrix);
				mismatches++;
			end
			if (got.row_index !== want.row_index) begin
				$error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
				mismatches++;
			end
			if (got.col0_value !== want.col0_value) begin
				$error("col0_value: expected %h, got %h", want.col0_value, got.col0_value);
				mismatches++;
			end
			if (got.col1_value !== want.col1_value) begin
				$error("col1_value: expected %h, got %h", want.col1_value, got.col1_value);
				mismatches++;
			end
			if (got.col2_value !== want.col2_value) begin
				$error("col2_value: expected %h, got %h", want.col2_value, got.col2_value);
				mismatches++;
			end
			if (got.singular !== want.singular) begin
				$error("singular: expected %0d, got %0d", want.singular, got.singular);
				mismatches++;
			end
			if (got.last_row !== want.last_row) begin
				$error("last_row: expected %0d, got %0d", want.last_row, got.last_row);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pd_cfg_if iter_cfg();
	pd_in_if  gradient();
	pd_out_if result();

	polar_decomposition_3x3 dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.iter_cfg(iter_cfg.sink),
		.gradient(gradient.sink),
		.result  (result.source)
	);

	polar_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int leftover_rows;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12ns * 25_000_000);
		$display("tb: failure");
		$finish;
	end

	// receiver back-pressure, changed at the falling edge
	always @(negedge clk)
		result.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		row_t got;
		if (arst_n && result.valid && result.ready) begin
			got.which_matrix = result.which_matrix;
			got.row_index    = result.row_index;
			got.col0_value   = result.col0_value;
			got.col1_value   = result.col1_value;
			got.col2_value   = result.col2_value;
			got.singular     = result.singular;
			got.last_row     = result.last_row;
			sb.check_row(got);
		end
	end

	task automatic wait_drained();
		while (sb.pending_rows.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_passes(input bit [4:0] count);
		wait_drained();
		repeat (4) @(negedge clk);
		iter_cfg.valid = 1'b1;
		iter_cfg.iteration_count = count;
		do @(posedge clk); while (!iter_cfg.ready);
		sb.passes = count;
		@(negedge clk);
		iter_cfg.valid = 1'b0;
	endtask

	task automatic send_gradient(input mat_t f);
		if (send_idle_pct != 0) begin
			while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		end
		gradient.valid = 1'b1;
		gradient.f11 = 32'(f[0]); gradient.f12 = 32'(f[1]); gradient.f13 = 32'(f[2]);
		gradient.f21 = 32'(f[3]); gradient.f22 = 32'(f[4]); gradient.f23 = 32'(f[5]);
		gradient.f31 = 32'(f[6]); gradient.f32 = 32'(f[7]); gradient.f33 = 32'(f[8]);
		do @(posedge clk); while (!gradient.ready);
		sb.note_gradient(f);
		@(negedge clk);
		gradient.valid = 1'b0;
	endtask

	function automatic longint pick_extreme();
		case ($urandom_range(5))
			0: return WMAX;
			1: return WMIN;
			2: return 0;
			3: return ONE;
			4: return -ONE;
			default: return longint'($signed($urandom));
		endcase
	endfunction

	// mostly near-identity gradients so the iteration converges; the rest noise or extreme values
	function automatic void random_gradient(output mat_t f);
		int kind;
		kind = $urandom_range(9);
		for (int i = 0; i < 9; i++) begin
			case (kind)
				6: f[i] = longint'($signed($urandom));
				7: f[i] = pick_extreme();
				9: f[i] = longint'($urandom_range(0, 1048575)) - 524288;
				default: f[i] = ((i % 4 == 0) ? ONE : 0)
					+ longint'($urandom_range(0, 65535)) - 32768;
			endcase
		end
		if (kind == 8)
			for (int j = 0; j < 3; j++) f[3+j] = f[j];
	endfunction

	task automatic random_batch(input int count, input int idle_mode);
		mat_t f;
		for (int n = 0; n < count; n++) begin
			send_idle_pct  = (idle_mode == 1) ? 47 : ((idle_mode == 3) ? 8 : 0);
			recv_stall_pct = (idle_mode == 2) ? 47 : ((idle_mode == 3) ? 8 : 0);
			random_gradient(f);
			send_gradient(f);
		end
	endtask

	task automatic directed_set();
		mat_t f;
		for (int k = 0; k < 8; k++) begin
			for (int i = 0; i < 9; i++) begin
				case (k)
					0: f[i] = (i % 4 == 0) ? ONE : 0;              // identity
					1: f[i] = 0;                                   // all zero, singular
					2: f[i] = WMAX;
					3: f[i] = WMIN;
					4: f[i] = (i % 4 == 0) ? -ONE : 0;             // reflection
					5: f[i] = (i == 1) ? -ONE : ((i == 3 || i == 8) ? ONE : 0);
					6: f[i] = (i % 4 == 0) ? 2 * ONE : ((i == 1) ? ONE / 2 : 0);
					default: f[i] = (i % 2) ? WMIN : WMAX;
				endcase
			end
			send_gradient(f);
		end
	endtask

	initial begin
		int waited;
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		iter_cfg.valid = 1'b0;
		iter_cfg.iteration_count = '0;
		gradient.valid = 1'b0;
		{gradient.f11, gradient.f12, gradient.f13} = '0;
		{gradient.f21, gradient.f22, gradient.f23} = '0;
		{gradient.f31, gradient.f32, gradient.f33} = '0;
		result.ready = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(negedge clk);

		// reset count of 15 first
		directed_set();
		write_passes(5'd31);
		random_batch(3, 3);
		write_passes(5'd0);
		directed_set();
		random_batch(40, 2);
		write_passes(5'd1);
		directed_set();
		random_batch(50, 0);
		wait_drained();
		random_batch(50, 1);
		write_passes(5'd2);
		random_batch(50, 2);
		random_batch(50, 3);
		write_passes(5'd3);
		random_batch(55, 0);

		waited = 0;
		while (sb.pending_rows.size() != 0 && waited < 2_000_000) begin
			@(posedge clk);
			waited++;
		end
		repeat (200) @(posedge clk);
		leftover_rows = sb.pending_rows.size();
		if (leftover_rows != 0) begin
			$error("%0d expected rows never arrived", leftover_rows);
			sb.mismatches++;
		end
		$display("covered %0d gradients (%0d singular), %0d rows checked",
			sb.gradients_seen, sb.singular_seen, sb.rows_checked);
		$display("pass counts 15, 31, 0, 1, 2, 3 under mixed sender and receiver idling");
		if (sb.mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/pd_pkg.sv
rtl/pd_if.sv
rtl/pd_mul.sv
rtl/pd_div.sv
rtl/polar_decomposition_3x3.sv
rtl/pd_checker.sv
verif/polar_decomposition_3x3_tb.sv
